// ===== hdl/ccbus_pkg.sv =====
// Shared types and constants of the console CPU bus.
package ccbus_pkg;

    localparam int SAMPLE_RATE_W = 18;
    localparam logic [SAMPLE_RATE_W-1:0] SAMPLE_RATE_RESET = 18'd44100;

    // Size of the CPU address window that the work RAM is mirrored over
    localparam int RAM_WINDOW = 8192;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [2:0] TGT_NONE = 3'd0;
    localparam logic [2:0] TGT_CART = 3'd1;
    localparam logic [2:0] TGT_RAM  = 3'd2;
    localparam logic [2:0] TGT_PPU  = 3'd3;
    localparam logic [2:0] TGT_APU  = 3'd4;
    localparam logic [2:0] TGT_PAD  = 3'd5;
    localparam logic [2:0] TGT_DMA  = 3'd6;

    localparam logic [15:0] ADDR_RAM_END    = 16'h2000;
    localparam logic [15:0] ADDR_PPU_END    = 16'h4000;
    localparam logic [15:0] ADDR_APU_LAST   = 16'h4013;
    localparam logic [15:0] ADDR_OAM_DMA    = 16'h4014;
    localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
    localparam logic [15:0] ADDR_PAD_ONE    = 16'h4016;
    localparam logic [15:0] ADDR_PAD_TWO    = 16'h4017;
    localparam logic [15:0] PPU_REG_MASK    = 16'h0007;

    localparam logic [2:0] TICK_PHASE_LAST = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        cart_claims;
        logic [7:0]  external_data;
        logic [7:0]  pad_one_buttons;
        logic [7:0]  pad_two_buttons;
        logic        ppu_vblank_nmi;
        logic        mapper_irq;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  target;
        logic [15:0] device_address;
        logic        cpu_clock_enable;
        logic        dma_active;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        sample_ready;
        logic        raise_nmi;
        logic        raise_irq;
    } t_result;

endpackage

// ===== hdl/ccbus_in_if.sv =====
// Input channel of the console CPU bus: bus items with valid/ready.
interface ccbus_in_if import ccbus_pkg::*;;
    logic  valid;
    logic  ready;
    t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/ccbus_out_if.sv =====
// Output channel of the console CPU bus: result items with valid/ready.
interface ccbus_out_if import ccbus_pkg::*;;
    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/console_cpu_bus_with_oam_dma.sv =====
// CPU bus of the console: address decode, work RAM, pads, OAM DMA, clock and audio pacing.
//
// i_item carries one bus item per transfer: a master clock tick, a CPU read or
// a CPU write, together with the cartridge claim, external read data, the live
// pad bytes and the interrupt requests. o_result returns exactly one result per
// item, in order. i_cfg_wr_en/i_cfg_wr_data write the audio sample rate; write
// it only while no item is in flight.
// An item passes an input register and then the result register before its
// result is offered. One item is taken every cycle while results are taken
// and no sweep runs; the work RAM has one write and one read port, and a RAM
// read lands in the read data register in step with the result register.
// After reset the work RAM is swept to zero, one entry per cycle, so i_item
// is not ready until the sweep ends. Configuration writes are taken throughout.
// When the receiver stalls, the result register holds, the input register
// fills, and then i_item drops ready until the result is taken.
// A tick enables the CPU on every third tick unless OAM DMA owns the bus; the
// DMA aligns, then alternates one bus read and one OAM write for 256 bytes.
module console_cpu_bus_with_oam_dma import ccbus_pkg::*; #(
    parameter int RAM_DEPTH       = 2048,
    parameter int MASTER_CLOCK_HZ = 5369318
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [SAMPLE_RATE_W-1:0] i_cfg_wr_data,
    ccbus_in_if.sink                 i_item,
    ccbus_out_if.source              o_result
);

    localparam int AW        = $clog2(RAM_DEPTH);
    localparam int ACC_W     = $clog2(MASTER_CLOCK_HZ);
    localparam int MOD_STEPS = $clog2(RAM_WINDOW / RAM_DEPTH) + 1;

    // Fold a RAM window address onto the RAM by restoring compare-subtract
    function automatic logic [AW-1:0] ram_index(input logic [12:0] a);
        logic [13:0] v;
        v = {1'b0, a};
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (v >= 14'(RAM_DEPTH << k)) begin
                v = v - 14'(RAM_DEPTH << k);
            end
        end
        return v[AW-1:0];
    endfunction

    // Configuration
    logic [SAMPLE_RATE_W-1:0] r_sample_rate;

    // Clearing sweep
    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;

    // Pipeline
    logic    r_s1_valid;
    t_item   r_s1;
    logic    r_out_valid;
    t_result r_out;
    logic    r_ram_sel;
    logic    adv;

    // Block state
    logic [2:0]       r_tick_phase, n_tick_phase;
    logic [7:0]       r_dma_page, n_dma_page;
    logic [7:0]       r_dma_offset, n_dma_offset;
    logic [7:0]       r_dma_byte, n_dma_byte;
    logic             r_dma_running, n_dma_running;
    logic             r_dma_waiting, n_dma_waiting;
    logic             r_dma_pend, n_dma_pend;
    logic [7:0]       r_pad_shift [2];
    logic [7:0]       n_pad_shift [2];
    logic [ACC_W-1:0] r_audio_acc, n_audio_acc;

    // Work RAM
    logic [7:0]    mem [RAM_DEPTH];
    logic [7:0]    r_ram_q;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata;

    // Decode and next-state
    t_result        res;
    logic           n_ram_sel;
    logic           dma_slot, dma_read, bus_rd, item_ram_we;
    logic [15:0]    ba;
    logic [AW-1:0]  ba_idx;
    logic [ACC_W:0] acc_sum;

    assign adv          = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_clearing && (!r_s1_valid || adv);

    assign dma_slot = (r_tick_phase == 3'd0) || (r_tick_phase == 3'd3);
    assign dma_read = (r_s1.action == ACT_TICK) && dma_slot && r_dma_running
                      && !r_dma_waiting && !r_tick_phase[0];
    assign bus_rd   = (r_s1.action == ACT_READ) || dma_read;
    assign ba       = dma_read ? {r_dma_page, r_dma_offset} : r_s1.address;
    assign ba_idx   = ram_index(ba[12:0]);
    assign acc_sum  = {1'b0, r_audio_acc}
                    + {{(ACC_W + 1 - SAMPLE_RATE_W){1'b0}}, r_sample_rate};

    always_comb begin
        res           = '0;
        n_ram_sel     = 1'b0;
        item_ram_we   = 1'b0;
        n_tick_phase  = r_tick_phase;
        n_dma_page    = r_dma_page;
        n_dma_offset  = r_dma_offset;
        n_dma_byte    = r_dma_pend ? r_ram_q : r_dma_byte;
        n_dma_running = r_dma_running;
        n_dma_waiting = r_dma_waiting;
        n_dma_pend    = 1'b0;
        n_pad_shift   = r_pad_shift;
        n_audio_acc   = r_audio_acc;

        // Bus read, shared by CPU reads and DMA reads
        if (bus_rd) begin
            if (r_s1.cart_claims) begin
                res.target         = TGT_CART;
                res.device_address = ba;
                res.read_data      = r_s1.external_data;
            end else if (ba < ADDR_RAM_END) begin
                res.target         = TGT_RAM;
                res.device_address = 16'(ba_idx);
                n_ram_sel          = 1'b1;
            end else if (ba < ADDR_PPU_END) begin
                res.target         = TGT_PPU;
                res.device_address = ba & PPU_REG_MASK;
                res.read_data      = r_s1.external_data;
            end else if (ba == ADDR_APU_STATUS) begin
                res.target         = TGT_APU;
                res.device_address = ba;
                res.read_data      = r_s1.external_data;
            end else if (ba inside {ADDR_PAD_ONE, ADDR_PAD_TWO}) begin
                res.target              = TGT_PAD;
                res.device_address      = ba;
                res.read_data           = {7'd0, r_pad_shift[ba[0]][7]};
                n_pad_shift[ba[0]]      = {r_pad_shift[ba[0]][6:0], 1'b0};
            end
        end

        case (r_s1.action)
            ACT_TICK: begin
                if (dma_slot) begin
                    if (!r_dma_running) begin
                        res.cpu_clock_enable = 1'b1;
                    end else if (r_dma_waiting) begin
                        if (r_tick_phase[0]) begin
                            n_dma_waiting = 1'b0;
                        end
                    end else if (dma_read) begin
                        // RAM data arrives registered: capture it from the read data register
                        n_dma_pend = n_ram_sel;
                        n_dma_byte = n_ram_sel ? r_dma_byte : res.read_data;
                    end else begin
                        res.oam_write = 1'b1;
                        res.oam_index = r_dma_offset;
                        res.oam_data  = r_dma_byte;
                        n_dma_offset  = r_dma_offset + 8'd1;
                        if (r_dma_offset == 8'hFF) begin
                            n_dma_running = 1'b0;
                            n_dma_waiting = 1'b1;
                        end
                    end
                end
                // A tick returns no read data to the CPU, not even from a DMA read
                res.read_data = 8'd0;
                n_ram_sel     = 1'b0;
                if (acc_sum >= (ACC_W + 1)'(MASTER_CLOCK_HZ)) begin
                    n_audio_acc      = ACC_W'(acc_sum - (ACC_W + 1)'(MASTER_CLOCK_HZ));
                    res.sample_ready = 1'b1;
                end else begin
                    n_audio_acc = acc_sum[ACC_W-1:0];
                end
                res.raise_nmi = r_s1.ppu_vblank_nmi;
                res.raise_irq = r_s1.mapper_irq;
                n_tick_phase  = (r_tick_phase == TICK_PHASE_LAST) ? 3'd0
                                                                  : r_tick_phase + 3'd1;
            end
            ACT_READ: begin
            end
            ACT_WRITE: begin
                if (r_s1.cart_claims) begin
                    res.target         = TGT_CART;
                    res.device_address = r_s1.address;
                end else if (r_s1.address < ADDR_RAM_END) begin
                    res.target         = TGT_RAM;
                    res.device_address = 16'(ba_idx);
                    item_ram_we        = 1'b1;
                end else if (r_s1.address < ADDR_PPU_END) begin
                    res.target         = TGT_PPU;
                    res.device_address = r_s1.address & PPU_REG_MASK;
                end else if (r_s1.address <= ADDR_APU_LAST
                             || r_s1.address == ADDR_APU_STATUS
                             || r_s1.address == ADDR_PAD_TWO) begin
                    res.target         = TGT_APU;
                    res.device_address = r_s1.address;
                end else if (r_s1.address == ADDR_OAM_DMA) begin
                    res.target         = TGT_DMA;
                    res.device_address = r_s1.address;
                    n_dma_page         = r_s1.write_data;
                    n_dma_offset       = 8'd0;
                    n_dma_running      = 1'b1;
                end else if (r_s1.address == ADDR_PAD_ONE) begin
                    // Latch both pads on a strobe write
                    res.target         = TGT_PAD;
                    res.device_address = r_s1.address;
                    n_pad_shift[0]     = r_s1.pad_one_buttons;
                    n_pad_shift[1]     = r_s1.pad_two_buttons;
                end
            end
            default: begin
                res       = '0;
                n_ram_sel = 1'b0;
            end
        endcase

        res.dma_active = n_dma_running;
    end

    assign ram_we    = r_clearing || (adv && item_ram_we);
    assign ram_waddr = r_clearing ? r_clr_idx : ba_idx;
    assign ram_wdata = r_clearing ? 8'd0 : r_s1.write_data;
    assign ram_re    = adv && bus_rd && !r_s1.cart_claims && (ba < ADDR_RAM_END);
    assign ram_raddr = ba_idx;

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re) begin
            r_ram_q <= mem[ram_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= SAMPLE_RATE_RESET;
        end else if (i_cfg_wr_en) begin
            r_sample_rate <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(RAM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_s1 <= i_item.payload;
        end
        if (adv) begin
            r_out     <= res;
            r_ram_sel <= n_ram_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_phase   <= 3'd0;
            r_dma_page     <= 8'd0;
            r_dma_offset   <= 8'd0;
            r_dma_byte     <= 8'd0;
            r_dma_running  <= 1'b0;
            r_dma_waiting  <= 1'b1;
            r_dma_pend     <= 1'b0;
            r_pad_shift[0] <= 8'd0;
            r_pad_shift[1] <= 8'd0;
            r_audio_acc    <= '0;
        end else begin
            r_dma_pend <= adv && n_dma_pend;
            if (adv || r_dma_pend) begin
                r_dma_byte <= n_dma_byte;
            end
            if (adv) begin
                r_tick_phase  <= n_tick_phase;
                r_dma_page    <= n_dma_page;
                r_dma_offset  <= n_dma_offset;
                r_dma_running <= n_dma_running;
                r_dma_waiting <= n_dma_waiting;
                r_pad_shift   <= n_pad_shift;
                r_audio_acc   <= n_audio_acc;
            end
        end
    end

    always_comb begin
        o_result.valid   = r_out_valid;
        o_result.payload = r_out;
        if (r_ram_sel) begin
            o_result.payload.read_data = r_ram_q;
        end
    end

    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_item.ready
    ) else $error("item taken during RAM clearing sweep");

    a_pend_one_cycle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_dma_pend |=> !r_dma_pend
    ) else $error("DMA RAM capture pending for more than one cycle");

    a_phase_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_tick_phase <= TICK_PHASE_LAST
    ) else $error("tick phase out of range");

    a_oam_no_bus: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.oam_write) |-> (r_out.target == TGT_NONE
                                              && !r_out.cpu_clock_enable)
    ) else $error("OAM write tick also drove the bus or the CPU");

    a_result_holds_ram: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> $stable(r_ram_q)
    ) else $error("RAM read data changed under a stalled result");

endmodule

// ===== test/bus_check_pkg.sv =====
// Scoreboard for the console CPU bus: tracks bus state and checks results in order.
package bus_check_pkg;
    import ccbus_pkg::*;

    localparam int RAM_DEPTH       = 2048;
    localparam int MASTER_CLOCK_HZ = 5369318;

    // the one action code that the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    class cpu_bus_scoreboard;
        logic [7:0]               ram_copy [RAM_DEPTH];
        logic [7:0]               pad_bits [2];
        logic [SAMPLE_RATE_W-1:0] sample_rate;
        int unsigned              clk_phase;
        int unsigned              audio_sum;
        logic [7:0]               dma_src_page;
        logic [7:0]               dma_pos;
        logic [7:0]               dma_latch;
        bit                       dma_busy;
        bit                       dma_align;
        int                       dma_done;
        int                       errors;
        t_result                  results_due [$];

        function new();
            foreach (ram_copy[i]) ram_copy[i] = '0;
            pad_bits[0]  = '0;
            pad_bits[1]  = '0;
            sample_rate  = SAMPLE_RATE_RESET;
            clk_phase    = 0;
            audio_sum    = 0;
            dma_src_page = '0;
            dma_pos      = '0;
            dma_latch    = '0;
            dma_busy     = 1'b0;
            dma_align    = 1'b1;
            dma_done     = 0;
            errors       = 0;
        endfunction

        function void set_rate(logic [SAMPLE_RATE_W-1:0] rate);
            sample_rate = rate;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // Bus read as the CPU or the DMA sees it; pad ports shift on every read
        function logic [7:0] decode_read(logic [15:0] a, logic cart, logic [7:0] ext,
                                         output logic [2:0] tgt, output logic [15:0] dev);
            int unsigned port;
            logic [7:0]  data;
            data = '0;
            tgt  = TGT_NONE;
            dev  = '0;
            if (cart) begin
                tgt  = TGT_CART;
                dev  = a;
                data = ext;
            end else if (a < ADDR_RAM_END) begin
                tgt  = TGT_RAM;
                dev  = a % RAM_DEPTH;
                data = ram_copy[dev];
            end else if (a < ADDR_PPU_END) begin
                tgt  = TGT_PPU;
                dev  = a & PPU_REG_MASK;
                data = ext;
            end else if (a == ADDR_APU_STATUS) begin
                tgt  = TGT_APU;
                dev  = a;
                data = ext;
            end else if (a == ADDR_PAD_ONE || a == ADDR_PAD_TWO) begin
                port           = a[0];
                data           = {7'b0, pad_bits[port][7]};
                pad_bits[port] = pad_bits[port] << 1;
                tgt            = TGT_PAD;
                dev            = a;
            end
            return data;
        endfunction

        // Work out the result of one accepted item and queue it
        function void note_item(t_item it);
            t_result     res;
            logic [2:0]  tgt;
            logic [15:0] dev;
            res = '0;
            case (it.action)
                ACT_TICK: begin
                    if (clk_phase % 3 == 0) begin
                        if (!dma_busy) begin
                            res.cpu_clock_enable = 1'b1;
                        end else if (dma_align) begin
                            if (clk_phase % 2 == 1) dma_align = 1'b0;
                        end else if (clk_phase % 2 == 0) begin
                            dma_latch = decode_read({dma_src_page, dma_pos}, it.cart_claims,
                                                    it.external_data, tgt, dev);
                            res.target         = tgt;
                            res.device_address = dev;
                        end else begin
                            res.oam_write = 1'b1;
                            res.oam_index = dma_pos;
                            res.oam_data  = dma_latch;
                            dma_pos       = dma_pos + 8'd1;
                            if (dma_pos == 8'd0) begin
                                dma_busy  = 1'b0;
                                dma_align = 1'b1;
                                dma_done++;
                            end
                        end
                    end
                    audio_sum += sample_rate;
                    if (audio_sum >= MASTER_CLOCK_HZ) begin
                        audio_sum -= MASTER_CLOCK_HZ;
                        res.sample_ready = 1'b1;
                    end
                    res.raise_nmi = it.ppu_vblank_nmi;
                    res.raise_irq = it.mapper_irq;
                    clk_phase = (clk_phase == TICK_PHASE_LAST) ? 0 : clk_phase + 1;
                end
                ACT_READ: begin
                    res.read_data = decode_read(it.address, it.cart_claims, it.external_data,
                                                tgt, dev);
                    res.target         = tgt;
                    res.device_address = dev;
                end
                ACT_WRITE: begin
                    if (it.cart_claims) begin
                        res.target         = TGT_CART;
                        res.device_address = it.address;
                    end else if (it.address < ADDR_RAM_END) begin
                        res.target         = TGT_RAM;
                        res.device_address = it.address % RAM_DEPTH;
                        ram_copy[it.address % RAM_DEPTH] = it.write_data;
                    end else if (it.address < ADDR_PPU_END) begin
                        res.target         = TGT_PPU;
                        res.device_address = it.address & PPU_REG_MASK;
                    end else if (it.address <= ADDR_APU_LAST || it.address == ADDR_APU_STATUS
                                 || it.address == ADDR_PAD_TWO) begin
                        res.target         = TGT_APU;
                        res.device_address = it.address;
                    end else if (it.address == ADDR_OAM_DMA) begin
                        // restart keeps the alignment state as it is
                        res.target         = TGT_DMA;
                        res.device_address = it.address;
                        dma_src_page       = it.write_data;
                        dma_pos            = '0;
                        dma_busy           = 1'b1;
                    end else if (it.address == ADDR_PAD_ONE) begin
                        res.target         = TGT_PAD;
                        res.device_address = it.address;
                        pad_bits[0]        = it.pad_one_buttons;
                        pad_bits[1]        = it.pad_two_buttons;
                    end
                end
                default: ;
            endcase
            res.dma_active = dma_busy;
            results_due.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (results_due.size() == 0) begin
                $error("result transfer with no expected result waiting");
                errors++;
                return;
            end
            want = results_due.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("target", want.target, got.target);
            compare_field("device_address", want.device_address, got.device_address);
            compare_field("cpu_clock_enable", want.cpu_clock_enable, got.cpu_clock_enable);
            compare_field("dma_active", want.dma_active, got.dma_active);
            compare_field("oam_write", want.oam_write, got.oam_write);
            compare_field("oam_index", want.oam_index, got.oam_index);
            compare_field("oam_data", want.oam_data, got.oam_data);
            compare_field("sample_ready", want.sample_ready, got.sample_ready);
            compare_field("raise_nmi", want.raise_nmi, got.raise_nmi);
            compare_field("raise_irq", want.raise_irq, got.raise_irq);
        endfunction
    endclass

endpackage

// ===== test/testbench.sv =====
// Top-level testbench of the console CPU bus: drives bus items and checks every result.
module testbench;
    import ccbus_pkg::*;
    import bus_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1300;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [SAMPLE_RATE_W-1:0] i_cfg_wr_data;

    ccbus_in_if  in_ch ();
    ccbus_out_if out_ch ();

    cpu_bus_scoreboard sb = new();

    int n_items;
    int tx_run_left;
    int retune_count;
    int cycle_count;
    bit hold_rx_req;

    console_cpu_bus_with_oam_dma #(
        .RAM_DEPTH       (RAM_DEPTH),
        .MASTER_CLOCK_HZ (MASTER_CLOCK_HZ)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (in_ch),
        .o_result      (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    function automatic t_item noise_item();
        t_item it;
        it.action          = 2'($urandom_range(0, 3));
        it.address         = 16'($urandom_range(0, 16'hFFFF));
        it.write_data      = 8'($urandom_range(0, 255));
        it.cart_claims     = 1'($urandom_range(0, 1));
        it.external_data   = 8'($urandom_range(0, 255));
        it.pad_one_buttons = 8'($urandom_range(0, 255));
        it.pad_two_buttons = 8'($urandom_range(0, 255));
        it.ppu_vblank_nmi  = 1'($urandom_range(0, 1));
        it.mapper_irq      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [15:0] pick_addr();
        logic [15:0] a;
        case ($urandom_range(0, 7))
            0: a = {3'b0, 2'($urandom_range(0, 3)), 5'b0, 6'($urandom_range(0, 63))};
            1, 2: a = 16'($urandom_range(0, int'(ADDR_RAM_END) - 1));
            3: a = 16'($urandom_range(int'(ADDR_RAM_END), int'(ADDR_PPU_END) - 1));
            4: a = 16'($urandom_range(int'(ADDR_PPU_END), int'(ADDR_PAD_TWO)));
            5: a = 16'($urandom_range(int'(ADDR_PAD_ONE), int'(ADDR_PAD_TWO)));
            6: a = 16'($urandom_range(int'(ADDR_PAD_TWO) + 1, 16'hFFFF));
            default: a = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return a;
    endfunction

    function automatic logic cart_draw();
        return $urandom_range(0, 3) == 0;
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [SAMPLE_RATE_W-1:0] next_rate();
        logic [SAMPLE_RATE_W-1:0] rate;
        case (retune_count)
            0: rate = 18'd1;
            1: rate = 18'd192000;
            2: rate = '0;
            3: rate = SAMPLE_RATE_RESET;
            default: begin
                case ($urandom_range(0, 3))
                    0: rate = 18'd1;
                    1: rate = 18'd192000;
                    2: rate = 18'($urandom_range(1, 192000));
                    default: rate = '1;
                endcase
            end
        endcase
        retune_count++;
        return rate;
    endfunction

    // Offer one item after a random gap and hold it until the transfer
    task automatic send(input t_item it);
        int gap;
        if (tx_run_left > 0) begin
            gap = 0;
            tx_run_left--;
        end else begin
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 29) == 0) tx_run_left = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_item(it);
        n_items++;
    endtask

    task automatic put(input logic [1:0] act, input logic [15:0] addr,
                       input logic [7:0] data, input logic cart);
        t_item it;
        it             = noise_item();
        it.action      = act;
        it.address     = addr;
        it.write_data  = data;
        it.cart_claims = cart;
        send(it);
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic set_sample_rate(input logic [SAMPLE_RATE_W-1:0] rate);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= rate;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_rate(rate);
    endtask

    task automatic mixed_run();
        int len;
        int r;
        int n;
        len = $urandom_range(20, 60);
        for (int j = 0; j < len; j++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                put(ACT_TICK, pick_addr(), any_byte(), cart_draw());
            end else if (r < 60) begin
                put(ACT_READ, pick_addr(), any_byte(), cart_draw());
            end else if (r < 82) begin
                put(ACT_WRITE, pick_addr(), any_byte(), cart_draw());
            end else if (r < 88) begin
                // latch the pads, then clock out some bits, sometimes past the eighth
                put(ACT_WRITE, ADDR_PAD_ONE, any_byte(), 1'b0);
                n = $urandom_range(1, 10);
                repeat (n)
                    put(ACT_READ, $urandom_range(0, 1) ? ADDR_PAD_TWO : ADDR_PAD_ONE,
                        any_byte(), $urandom_range(0, 7) == 0);
            end else if (r < 92) begin
                put(ACT_WRITE, ADDR_OAM_DMA, any_byte(), 1'b0);
            end else if (r < 95) begin
                put(ACT_UNUSED, pick_addr(), any_byte(), cart_draw());
            end else begin
                send(noise_item());
            end
        end
    endtask

    // Start a DMA, restart it once, and tick it through to the last byte
    task automatic full_dma_run();
        int r;
        logic [15:0] a;
        put(ACT_WRITE, ADDR_OAM_DMA, any_byte(), 1'b0);
        for (int k = 0; sb.dma_busy; k++) begin
            if (k == 500) begin
                hold_rx_req = 1'b1;
                tx_run_left = 80;
            end
            if (k % 300 == 299) set_sample_rate(next_rate());
            r = $urandom_range(0, 99);
            if (k == 40) begin
                put(ACT_WRITE, ADDR_OAM_DMA, any_byte(), 1'b0);
            end else if (r < 85) begin
                put(ACT_TICK, pick_addr(), any_byte(), cart_draw());
            end else if (r < 93) begin
                put(ACT_READ, pick_addr(), any_byte(), cart_draw());
            end else begin
                // keep the running DMA out of reach of stray restarts
                a = pick_addr();
                put(ACT_WRITE, a, any_byte(), a == ADDR_OAM_DMA || cart_draw());
            end
        end
    endtask

    // Result side: random stalls, quiet stretches and a long hold-off on each request
    initial begin
        int      stall;
        int      run_left;
        t_result got;
        out_ch.ready <= 1'b0;
        run_left = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_rx_req) begin
                stall       = HOLD_CYCLES;
                hold_rx_req = 1'b0;
            end else if (run_left > 0) begin
                stall = 0;
                run_left--;
            end else begin
                stall = $urandom_range(0, 14);
                if ($urandom_range(0, 29) == 0) run_left = $urandom_range(20, 60);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            got = out_ch.payload;
            sb.check_result(got);
        end
    end

    initial begin
        int ep;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        n_items      = 0;
        tx_run_left  = 0;
        retune_count = 0;
        hold_rx_req  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_sample_rate('1);

        // directed: decode edges, RAM mirrors, pads, unmapped, cartridge, DMA start
        put(ACT_READ, 16'h0000, 8'h00, 1'b0);
        put(ACT_WRITE, 16'h07FF, 8'hFF, 1'b0);
        put(ACT_READ, 16'h1FFF, 8'h00, 1'b0);
        put(ACT_WRITE, 16'h0800, 8'h00, 1'b0);
        put(ACT_READ, 16'h0000, 8'hFF, 1'b0);
        put(ACT_READ, ADDR_RAM_END, 8'h00, 1'b0);
        put(ACT_WRITE, ADDR_PPU_END - 16'd1, 8'hA5, 1'b0);
        put(ACT_READ, ADDR_APU_STATUS, 8'h00, 1'b0);
        put(ACT_WRITE, ADDR_PPU_END, 8'h3C, 1'b0);
        put(ACT_WRITE, ADDR_APU_LAST, 8'hC3, 1'b0);
        put(ACT_WRITE, ADDR_PAD_TWO, 8'h0F, 1'b0);
        put(ACT_READ, ADDR_APU_LAST, 8'h00, 1'b0);
        put(ACT_WRITE, ADDR_PAD_ONE, 8'h01, 1'b0);
        put(ACT_READ, ADDR_PAD_ONE, 8'h00, 1'b0);
        put(ACT_READ, ADDR_PAD_TWO, 8'h00, 1'b0);
        put(ACT_READ, 16'hFFFF, 8'h00, 1'b1);
        put(ACT_WRITE, 16'h8000, 8'h77, 1'b1);
        put(ACT_READ, 16'hFFFF, 8'h00, 1'b0);
        put(ACT_WRITE, ADDR_PAD_TWO + 16'd1, 8'hFF, 1'b0);
        put(ACT_UNUSED, 16'hFFFF, 8'hFF, 1'b1);
        put(ACT_WRITE, ADDR_OAM_DMA, 8'h40, 1'b0);
        repeat (4) put(ACT_TICK, 16'h0000, 8'h00, 1'b0);

        ep = 0;
        while (n_items < ITEM_TARGET || sb.dma_done == 0) begin
            if (ep % 2 == 1) set_sample_rate(next_rate());
            if (ep == 2) begin
                hold_rx_req = 1'b1;
                tx_run_left = 80;
            end
            if (sb.dma_done == 0 && n_items >= 300) full_dma_run();
            else mixed_run();
            ep++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ccbus_pkg.sv
hdl/ccbus_in_if.sv
hdl/ccbus_out_if.sv
hdl/console_cpu_bus_with_oam_dma.sv
test/bus_check_pkg.sv
test/testbench.sv
